@@ rtl/core/cmtn_pkg.sv @@
// ----------------------------------------------------------------------------
// cmtn_pkg
// Types and constants shared by the cube map tile neighbor core.
// ----------------------------------------------------------------------------
`default_nettype none

package cmtn_pkg;

  localparam int MAX_LEVEL = 15;
  localparam int COORD_W   = 15;
  localparam int FACE_W    = 3;
  localparam int LEVEL_W   = 4;

  typedef enum logic [1:0] {
    DIR_NORTH,
    DIR_SOUTH,
    DIR_WEST,
    DIR_EAST
  } dir_t;

  localparam logic [FACE_W-1:0] FACE_0 = 3'd0;
  localparam logic [FACE_W-1:0] FACE_1 = 3'd1;
  localparam logic [FACE_W-1:0] FACE_2 = 3'd2;
  localparam logic [FACE_W-1:0] FACE_3 = 3'd3;
  localparam logic [FACE_W-1:0] FACE_4 = 3'd4;
  localparam logic [FACE_W-1:0] FACE_5 = 3'd5;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    dir_t                direction;
    logic [FACE_W-1:0]   page_face;
    logic [LEVEL_W-1:0]  page_level;
    coord_t              page_row;
    coord_t              page_col;
  } req_t;

  typedef struct packed {
    logic [FACE_W-1:0]   next_face;
    coord_t              next_row;
    coord_t              next_col;
    logic                out_of_range;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/cmtn_neighbor.sv @@
// ----------------------------------------------------------------------------
// cmtn_neighbor
// Neighbour tile lookup: step within a face or cross to the adjacent face.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtn_neighbor (
  input  wire cmtn_pkg::req_t req,
  output cmtn_pkg::rsp_t      rsp
);

  logic [cmtn_pkg::LEVEL_W-1:0] lvl;
  cmtn_pkg::coord_t             m;
  cmtn_pkg::coord_t             t_ns;
  cmtn_pkg::coord_t             t_we;
  cmtn_pkg::coord_t             r;
  cmtn_pkg::coord_t             c;
  logic [cmtn_pkg::FACE_W-1:0]  a;

  always_comb begin
    lvl = (int'(req.page_level) > cmtn_pkg::MAX_LEVEL) ?
          cmtn_pkg::LEVEL_W'(cmtn_pkg::MAX_LEVEL) : req.page_level;
    for (int i = 0; i < cmtn_pkg::COORD_W; i++) begin
      m[i] = (i < int'(lvl));
    end
  end

  assign r    = req.page_row;
  assign c    = req.page_col;
  assign a    = req.page_face;
  assign t_ns = m - c;
  assign t_we = m - r;

  always_comb begin
    rsp.next_face    = a;
    rsp.next_row     = r;
    rsp.next_col     = c;
    rsp.out_of_range = (r > m) || (c > m);
    if (!rsp.out_of_range) begin
      unique case (req.direction)
        cmtn_pkg::DIR_NORTH: begin
          if (r != '0) begin
            rsp.next_row = r - cmtn_pkg::COORD_W'(1);
          end else begin
            unique case (a)
              cmtn_pkg::FACE_0: begin
                rsp.next_face = cmtn_pkg::FACE_2; rsp.next_row = t_ns; rsp.next_col = m;
              end
              cmtn_pkg::FACE_1: begin
                rsp.next_face = cmtn_pkg::FACE_2; rsp.next_row = c; rsp.next_col = '0;
              end
              cmtn_pkg::FACE_2: begin
                rsp.next_face = cmtn_pkg::FACE_5; rsp.next_row = '0; rsp.next_col = t_ns;
              end
              cmtn_pkg::FACE_3: begin
                rsp.next_face = cmtn_pkg::FACE_4; rsp.next_row = m;
              end
              cmtn_pkg::FACE_4: begin
                rsp.next_face = cmtn_pkg::FACE_2; rsp.next_row = m;
              end
              default: begin
                rsp.next_face = cmtn_pkg::FACE_2; rsp.next_row = '0; rsp.next_col = t_ns;
              end
            endcase
          end
        end
        cmtn_pkg::DIR_SOUTH: begin
          if (r < m) begin
            rsp.next_row = r + cmtn_pkg::COORD_W'(1);
          end else begin
            unique case (a)
              cmtn_pkg::FACE_0: begin
                rsp.next_face = cmtn_pkg::FACE_3; rsp.next_row = c; rsp.next_col = m;
              end
              cmtn_pkg::FACE_1: begin
                rsp.next_face = cmtn_pkg::FACE_3; rsp.next_row = t_ns; rsp.next_col = '0;
              end
              cmtn_pkg::FACE_2: begin
                rsp.next_face = cmtn_pkg::FACE_4; rsp.next_row = '0;
              end
              cmtn_pkg::FACE_3: begin
                rsp.next_face = cmtn_pkg::FACE_5; rsp.next_row = m; rsp.next_col = t_ns;
              end
              cmtn_pkg::FACE_4: begin
                rsp.next_face = cmtn_pkg::FACE_3; rsp.next_row = '0;
              end
              default: begin
                rsp.next_face = cmtn_pkg::FACE_3; rsp.next_row = m; rsp.next_col = t_ns;
              end
            endcase
          end
        end
        cmtn_pkg::DIR_WEST: begin
          if (c != '0) begin
            rsp.next_col = c - cmtn_pkg::COORD_W'(1);
          end else begin
            unique case (a)
              cmtn_pkg::FACE_0: begin
                rsp.next_face = cmtn_pkg::FACE_4; rsp.next_col = m;
              end
              cmtn_pkg::FACE_1: begin
                rsp.next_face = cmtn_pkg::FACE_5; rsp.next_col = m;
              end
              cmtn_pkg::FACE_2: begin
                rsp.next_face = cmtn_pkg::FACE_1; rsp.next_col = r; rsp.next_row = '0;
              end
              cmtn_pkg::FACE_3: begin
                rsp.next_face = cmtn_pkg::FACE_1; rsp.next_col = t_we; rsp.next_row = m;
              end
              cmtn_pkg::FACE_4: begin
                rsp.next_face = cmtn_pkg::FACE_1; rsp.next_col = m;
              end
              default: begin
                rsp.next_face = cmtn_pkg::FACE_0; rsp.next_col = m;
              end
            endcase
          end
        end
        cmtn_pkg::DIR_EAST: begin
          if (c < m) begin
            rsp.next_col = c + cmtn_pkg::COORD_W'(1);
          end else begin
            unique case (a)
              cmtn_pkg::FACE_0: begin
                rsp.next_face = cmtn_pkg::FACE_5; rsp.next_col = '0;
              end
              cmtn_pkg::FACE_1: begin
                rsp.next_face = cmtn_pkg::FACE_4; rsp.next_col = '0;
              end
              cmtn_pkg::FACE_2: begin
                rsp.next_face = cmtn_pkg::FACE_0; rsp.next_col = t_we; rsp.next_row = '0;
              end
              cmtn_pkg::FACE_3: begin
                rsp.next_face = cmtn_pkg::FACE_0; rsp.next_col = r; rsp.next_row = m;
              end
              cmtn_pkg::FACE_4: begin
                rsp.next_face = cmtn_pkg::FACE_0; rsp.next_col = '0;
              end
              default: begin
                rsp.next_face = cmtn_pkg::FACE_1; rsp.next_col = '0;
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cube_map_tile_neighbor_core.sv @@
// ----------------------------------------------------------------------------
// cube_map_tile_neighbor_core
// Neighbour of a cube map quadtree tile in one of four directions.
//
// Request channel (req_valid, req_stall, req) carries a tile and a direction;
// response channel (rsp_valid, rsp_stall, rsp) carries the neighbouring
// tile's face, row and column and a flag for a tile outside its face.
// An item is taken on an edge where valid is high and stall is low.
// Each item passes an input register, the face-edge lookup logic and a
// result register, and rsp_valid rises when the result register takes it.
// Throughput is one item per cycle while the receiver does not stall, set
// by the combinational lookup between the two registers. With the receiver
// stalled the result register holds its item and the input register takes
// one more; req_stall then rises and stays high until the receiver takes
// the result. req_stall is low in every cycle in which rsp_stall is low.
// Synchronous reset empties both registers; no item is lost or repeated
// across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_tile_neighbor_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire cmtn_pkg::req_t req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output cmtn_pkg::rsp_t      rsp
);

  logic           in_valid;
  cmtn_pkg::req_t in_item;
  cmtn_pkg::rsp_t lookup;
  logic           rsp_free;
  logic           in_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign in_free   = !in_valid || rsp_free;
  assign req_stall = !in_free;

  cmtn_neighbor u_neighbor (
    .req (in_item),
    .rsp (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= req_valid;
    end
    if (in_free && req_valid) begin
      in_item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= in_valid;
    end
    if (rsp_free && in_valid) begin
      rsp <= lookup;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cmtn_checker.sv @@
// ----------------------------------------------------------------------------
// cmtn_checker
// Port-level checks on the tile neighbour core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cmtn_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 req_valid,
  input wire                 req_stall,
  input wire cmtn_pkg::req_t req,
  input wire                 rsp_valid,
  input wire                 rsp_stall,
  input wire cmtn_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_no_backpressure: assert property (@(posedge clk)
    !rsp_stall |-> !req_stall)
    else $error("request stalled while response side is free");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall && !$past(rst) &&
    $past(rsp_valid && rsp_stall && req_valid && !req_stall) |-> req_stall)
    else $error("request taken with both registers full");

endmodule

bind cube_map_tile_neighbor_core cmtn_checker u_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for cube_map_tile_neighbor_core.
//
// Sends tile queries through the request channel and checks every response
// against a predictor of the face and edge mapping. It covers every face
// crossing, out-of-range tiles, the spare face codes and random traffic.
// The sender idles between bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [cmtn_pkg::FACE_W-1:0] FACE_SPARE_6 = 3'd6;
  localparam logic [cmtn_pkg::FACE_W-1:0] FACE_SPARE_7 = 3'd7;
  localparam int COORD_TOP = (1 << cmtn_pkg::COORD_W) - 1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cmtn_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cmtn_pkg::rsp_t rsp;

  cmtn_pkg::rsp_t expected_tiles[$];
  cmtn_pkg::rsp_t want_tile;
  int             mismatches = 0;
  stall_mode_t    stall_mode = STALL_NONE;
  int             stall_run = 0;
  int             max_gap = 0;
  int             burst_left = 0;

  cube_map_tile_neighbor_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cmtn_pkg::rsp_t neighbor_of(cmtn_pkg::req_t q);
    cmtn_pkg::rsp_t                o;
    logic [3:0]                    lvl;
    logic [15:0]                   m;
    logic [15:0]                   r;
    logic [15:0]                   c;
    logic [15:0]                   tc;
    logic [15:0]                   tr;
    logic [cmtn_pkg::FACE_W-1:0]   f;
    lvl = q.page_level;
    if (lvl > cmtn_pkg::MAX_LEVEL) lvl = 4'(cmtn_pkg::MAX_LEVEL);
    m = (16'd1 << lvl) - 16'd1;
    r = {1'b0, q.page_row};
    c = {1'b0, q.page_col};
    f = q.page_face;
    o.out_of_range = (r > m) || (c > m);
    if (o.out_of_range) begin
      o.next_face = f;
      o.next_row  = q.page_row;
      o.next_col  = q.page_col;
      return o;
    end
    tc = m - c;
    tr = m - r;
    case (q.direction)
      cmtn_pkg::DIR_NORTH: begin
        if (r != 0) r = r - 16'd1;
        else case (f)
          cmtn_pkg::FACE_0: begin f = cmtn_pkg::FACE_2; r = tc; c = m; end
          cmtn_pkg::FACE_1: begin f = cmtn_pkg::FACE_2; r = c; c = '0; end
          cmtn_pkg::FACE_2: begin f = cmtn_pkg::FACE_5; r = '0; c = tc; end
          cmtn_pkg::FACE_3: begin f = cmtn_pkg::FACE_4; r = m; end
          cmtn_pkg::FACE_4: begin f = cmtn_pkg::FACE_2; r = m; end
          default: begin f = cmtn_pkg::FACE_2; r = '0; c = tc; end
        endcase
      end
      cmtn_pkg::DIR_SOUTH: begin
        if (r < m) r = r + 16'd1;
        else case (f)
          cmtn_pkg::FACE_0: begin f = cmtn_pkg::FACE_3; r = c; c = m; end
          cmtn_pkg::FACE_1: begin f = cmtn_pkg::FACE_3; r = tc; c = '0; end
          cmtn_pkg::FACE_2: begin f = cmtn_pkg::FACE_4; r = '0; end
          cmtn_pkg::FACE_3: begin f = cmtn_pkg::FACE_5; r = m; c = tc; end
          cmtn_pkg::FACE_4: begin f = cmtn_pkg::FACE_3; r = '0; end
          default: begin f = cmtn_pkg::FACE_3; r = m; c = tc; end
        endcase
      end
      cmtn_pkg::DIR_WEST: begin
        if (c != 0) c = c - 16'd1;
        else case (f)
          cmtn_pkg::FACE_0: begin f = cmtn_pkg::FACE_4; c = m; end
          cmtn_pkg::FACE_1: begin f = cmtn_pkg::FACE_5; c = m; end
          cmtn_pkg::FACE_2: begin f = cmtn_pkg::FACE_1; c = r; r = '0; end
          cmtn_pkg::FACE_3: begin f = cmtn_pkg::FACE_1; c = tr; r = m; end
          cmtn_pkg::FACE_4: begin f = cmtn_pkg::FACE_1; c = m; end
          default: begin f = cmtn_pkg::FACE_0; c = m; end
        endcase
      end
      default: begin
        if (c < m) c = c + 16'd1;
        else case (f)
          cmtn_pkg::FACE_0: begin f = cmtn_pkg::FACE_5; c = '0; end
          cmtn_pkg::FACE_1: begin f = cmtn_pkg::FACE_4; c = '0; end
          cmtn_pkg::FACE_2: begin f = cmtn_pkg::FACE_0; c = tr; r = '0; end
          cmtn_pkg::FACE_3: begin f = cmtn_pkg::FACE_0; c = r; r = m; end
          cmtn_pkg::FACE_4: begin f = cmtn_pkg::FACE_0; c = '0; end
          default: begin f = cmtn_pkg::FACE_1; c = '0; end
        endcase
      end
    endcase
    o.next_face = f;
    o.next_row  = r[cmtn_pkg::COORD_W-1:0];
    o.next_col  = c[cmtn_pkg::COORD_W-1:0];
    return o;
  endfunction

  function automatic cmtn_pkg::req_t random_tile();
    cmtn_pkg::req_t q;
    int             pick;
    int             lvl;
    int             m;
    pick = $urandom_range(0, 19);
    q.direction = cmtn_pkg::dir_t'($urandom_range(0, 3));
    q.page_face = ($urandom_range(0, 15) == 0) ?
                  cmtn_pkg::FACE_W'($urandom_range(6, 7)) :
                  cmtn_pkg::FACE_W'($urandom_range(0, 5));
    if (pick == 0) begin
      q.page_face  = cmtn_pkg::FACE_W'($urandom);
      q.page_level = cmtn_pkg::LEVEL_W'($urandom);
      q.page_row   = cmtn_pkg::COORD_W'($urandom);
      q.page_col   = cmtn_pkg::COORD_W'($urandom);
      return q;
    end
    lvl = ($urandom_range(0, 3) == 0) ? cmtn_pkg::MAX_LEVEL
                                      : $urandom_range(0, cmtn_pkg::MAX_LEVEL);
    if (pick == 1) lvl = $urandom_range(0, cmtn_pkg::MAX_LEVEL - 1);
    m = (1 << lvl) - 1;
    q.page_level = cmtn_pkg::LEVEL_W'(lvl);
    q.page_row   = cmtn_pkg::COORD_W'($urandom_range(0, m));
    q.page_col   = cmtn_pkg::COORD_W'($urandom_range(0, m));
    case ($urandom_range(0, 4))
      0: q.page_row = '0;
      1: q.page_row = cmtn_pkg::COORD_W'(m);
      2: q.page_col = '0;
      3: q.page_col = cmtn_pkg::COORD_W'(m);
      default: ;
    endcase
    if (pick == 1) begin
      if ($urandom_range(0, 1) == 0)
        q.page_row = cmtn_pkg::COORD_W'($urandom_range(m + 1, COORD_TOP));
      else
        q.page_col = cmtn_pkg::COORD_W'($urandom_range(m + 1, COORD_TOP));
    end
    return q;
  endfunction

  // receiver: alternate stall and release runs
  always @(posedge clk) begin
    if (rst || stall_mode == STALL_NONE) begin
      rsp_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      rsp_stall <= !rsp_stall;
      if (stall_mode == STALL_LIGHT)
        stall_run <= rsp_stall ? $urandom_range(1, 8) : $urandom_range(0, 2);
      else
        stall_run <= rsp_stall ? $urandom_range(0, 3) : $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        expected_tiles.insert(expected_tiles.size(), neighbor_of(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_tiles.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: face %0d row %0d col %0d oor %0d",
                   $time, rsp.next_face, rsp.next_row, rsp.next_col, rsp.out_of_range);
        end else begin
          want_tile = expected_tiles.pop_front();
          if (rsp.next_face !== want_tile.next_face) begin
            mismatches++;
            $display("%0t: next_face expected %0d actual %0d",
                     $time, want_tile.next_face, rsp.next_face);
          end
          if (rsp.next_row !== want_tile.next_row) begin
            mismatches++;
            $display("%0t: next_row expected %0d actual %0d",
                     $time, want_tile.next_row, rsp.next_row);
          end
          if (rsp.next_col !== want_tile.next_col) begin
            mismatches++;
            $display("%0t: next_col expected %0d actual %0d",
                     $time, want_tile.next_col, rsp.next_col);
          end
          if (rsp.out_of_range !== want_tile.out_of_range) begin
            mismatches++;
            $display("%0t: out_of_range expected %0d actual %0d",
                     $time, want_tile.out_of_range, rsp.out_of_range);
          end
        end
      end
    end
  end

  task automatic send_item(input cmtn_pkg::req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_tiles.size() != 0);
  endtask

  task automatic send_tile(input cmtn_pkg::dir_t d, input logic [cmtn_pkg::FACE_W-1:0] f,
                           input int lvl, input int row, input int col);
    cmtn_pkg::req_t q;
    q.direction  = d;
    q.page_face  = f;
    q.page_level = cmtn_pkg::LEVEL_W'(lvl);
    q.page_row   = cmtn_pkg::COORD_W'(row);
    q.page_col   = cmtn_pkg::COORD_W'(col);
    send_item(q);
  endtask

  task automatic test_face_crossings();
    int f;
    int d;
    int lvl;
    int m;
    int other;
    for (f = 0; f < 6; f++) begin
      for (d = 0; d < 4; d++) begin
        case ((f * 4 + d) % 3)
          0: lvl = 0;
          1: lvl = cmtn_pkg::MAX_LEVEL;
          default: lvl = $urandom_range(1, cmtn_pkg::MAX_LEVEL - 1);
        endcase
        m = (1 << lvl) - 1;
        other = (d % 2 == 0) ? m : $urandom_range(0, m);
        case (cmtn_pkg::dir_t'(d))
          cmtn_pkg::DIR_NORTH:
            send_tile(cmtn_pkg::DIR_NORTH, cmtn_pkg::FACE_W'(f), lvl, 0, other);
          cmtn_pkg::DIR_SOUTH:
            send_tile(cmtn_pkg::DIR_SOUTH, cmtn_pkg::FACE_W'(f), lvl, m, other);
          cmtn_pkg::DIR_WEST:
            send_tile(cmtn_pkg::DIR_WEST, cmtn_pkg::FACE_W'(f), lvl, other, 0);
          default:
            send_tile(cmtn_pkg::DIR_EAST, cmtn_pkg::FACE_W'(f), lvl, other, m);
        endcase
      end
    end
  endtask

  task automatic test_special_tiles();
    send_tile(cmtn_pkg::DIR_NORTH, cmtn_pkg::FACE_0, 0, 0, 0);
    send_tile(cmtn_pkg::DIR_SOUTH, cmtn_pkg::FACE_3, 3, 8, 2);
    send_tile(cmtn_pkg::DIR_WEST, cmtn_pkg::FACE_5, 0, 0, COORD_TOP);
    send_tile(cmtn_pkg::DIR_NORTH, FACE_SPARE_6, 4, 5, 5);
    send_tile(cmtn_pkg::DIR_SOUTH, FACE_SPARE_6, 2, 3, 1);
    send_tile(cmtn_pkg::DIR_EAST, FACE_SPARE_7, cmtn_pkg::MAX_LEVEL, COORD_TOP, COORD_TOP);
    wait_drained();
  endtask

  task automatic run_random(input int count);
    int n;
    for (n = 0; n < count; n++) send_item(random_tile());
    wait_drained();
  endtask

  task automatic test_streaming();
    stall_mode = STALL_NONE;
    max_gap    = 0;
    run_random(480);
  endtask

  task automatic test_sender_gaps();
    stall_mode = STALL_NONE;
    max_gap    = 8;
    run_random(480);
  endtask

  task automatic test_receiver_stalls();
    stall_mode = STALL_HEAVY;
    max_gap    = 0;
    run_random(480);
  endtask

  task automatic test_both_idle();
    stall_mode = STALL_LIGHT;
    max_gap    = 4;
    run_random(480);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_face_crossings();
    test_special_tiles();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    stall_mode = STALL_NONE;
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
